// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the segmenter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is checked during reset as well
`define STS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants for the sonar track segmenter.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Width of the internal gap counter
    localparam int GAP_WIDTH = 16;
    localparam logic [GAP_WIDTH-1:0] GAP_MAX = {GAP_WIDTH{1'b1}};

    // Field widths
    localparam int HEADING_W   = 12;
    localparam int POS_W       = 32;
    localparam int TOL_W       = 11;
    localparam int MAXL_W      = 16;
    localparam int GAP_COUNT_W = 16;

    // Heading circle in tenths of a degree
    localparam logic [HEADING_W-1:0] FULL_CIRCLE = 12'd3600;
    localparam logic [HEADING_W-1:0] HALF_CIRCLE = 12'd1800;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADING_TOL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LINES   = 2'd1;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [TOL_W-1:0]  TOL_RESET  = 11'd200;
    localparam logic [MAXL_W-1:0] MAXL_RESET = 16'd1000;

    // Stream widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [TOL_W-1:0]  heading_tolerance;
        logic [MAXL_W-1:0] max_segment_lines;
    } cfg_t;

    typedef struct packed {
        logic [HEADING_W-1:0]    heading;
        logic signed [POS_W-1:0] easting;
        logic signed [POS_W-1:0] northing;
        logic                    last_line;
    } item_t;

    typedef struct packed {
        logic                   segment_break;
        logic                   turned;
        logic                   no_fix;
        logic                   too_long;
        logic [GAP_COUNT_W-1:0] gap_count;
    } result_t;

endpackage

// ===== sv/sonar_track_segmenter.sv =====
// ----------------------------------------------------------------------------
// sonar_track_segmenter
// Splits a stream of sonar ping headers into track segments.
// ----------------------------------------------------------------------------
// One ping header is taken per clock cycle unless stalled, and one result item
// leaves for every ping: the ping lands in an input register, the heading
// compare and gap counter update run against the stored track state, and the
// flags go into the result register. While the result register is stalled the
// input register still takes one more item. The user must write configuration
// through the cfg channel only while no item is in flight; the block does not
// enforce it. Index 0 is the heading tolerance, index 1 the segment length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sonar_track_segmenter (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Ping header input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // heading[11:0], easting[43:12], northing[75:44], zero pad[79:76]
    input  logic [sts_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    // Segment result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // segment_break[0], turned[1], no_fix[2], too_long[3], gap_count[19:4],
    // zero pad[23:20]
    output logic [sts_pkg::OUT_DATA_W-1:0]  m_tdata
);

    sts_pkg::cfg_t    cfg;
    sts_pkg::item_t   s_item;
    sts_pkg::item_t   s1_item_reg;
    sts_pkg::result_t result;
    sts_pkg::result_t out_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             s_fire;
    logic             s1_advance;

    sts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the incoming item
    always_comb
    begin
        s_item.heading   = s_tdata[11:0];
        s_item.easting   = s_tdata[43:12];
        s_item.northing  = s_tdata[75:44];
        s_item.last_line = s_tlast;
    end

    // Handshake: the input stage moves on whenever the result slot is free
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_fire     = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    sts_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (s1_advance),
        .item   (s1_item_reg),
        .result (result)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
            s1_item_reg <= s_item;
        if (s1_advance)
            out_reg <= result;
    end

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.gap_count, out_reg.too_long,
                       out_reg.no_fix, out_reg.turned, out_reg.segment_break};

    // Checks
    `STS_ASSERT(a_advance_fills_out, clk, rst_n, s1_advance |=> m_tvalid, "result lost after input stage moved")
    `STS_ASSERT(a_stage_holds, clk, rst_n, s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_item_reg), "input stage dropped a waiting item")
    `STS_ASSERT(a_no_overwrite, clk, rst_n, m_tvalid && !m_tready |-> !s1_advance, "result overwritten while stalled")

endmodule

// ===== sv/sts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sts_cfg_regs
// Configuration register file for the segmenter (tolerance, segment length).
// ----------------------------------------------------------------------------
module sts_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sts_pkg::cfg_t                    cfg
);

    sts_pkg::cfg_t cfg_reg;
    sts_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sts_pkg::CFG_HEADING_TOL:
                    cfg_next.heading_tolerance = cfg_data[sts_pkg::TOL_W-1:0];
                sts_pkg::CFG_MAX_LINES:
                    cfg_next.max_segment_lines = cfg_data[sts_pkg::MAXL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heading_tolerance <= sts_pkg::TOL_RESET;
            cfg_reg.max_segment_lines <= sts_pkg::MAXL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/sts_core.sv =====
// ----------------------------------------------------------------------------
// sts_core
// Break decision and track state: heading reference, gap counter, first ping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sts_core (
    input  logic             clk,
    input  logic             rst_n,
    input  sts_pkg::cfg_t    cfg,
    input  logic             fire,
    input  sts_pkg::item_t   item,
    output sts_pkg::result_t result
);

    logic [sts_pkg::HEADING_W-1:0] heading_reference_reg;
    logic [sts_pkg::HEADING_W-1:0] heading_reference_next;
    logic [sts_pkg::GAP_WIDTH-1:0] pings_reg;
    logic [sts_pkg::GAP_WIDTH-1:0] pings_next;
    logic                          first_ping_reg;
    logic                          first_ping_next;

    logic [sts_pkg::HEADING_W-1:0] hd;
    logic [sts_pkg::HEADING_W-1:0] diff_abs;
    logic [sts_pkg::HEADING_W-1:0] diff;
    logic [sts_pkg::GAP_WIDTH-1:0] gap;
    logic [31:0]                   gap_ext;
    logic                          turned;
    logic                          no_fix;
    logic                          too_long;
    logic                          brk;

    // Heading folded once into the circle, then circular distance
    always_comb
    begin
        hd = (item.heading >= sts_pkg::FULL_CIRCLE) ?
             item.heading - sts_pkg::FULL_CIRCLE : item.heading;
        diff_abs = (hd >= heading_reference_reg) ? hd - heading_reference_reg
                                                 : heading_reference_reg - hd;
        diff = (diff_abs > sts_pkg::HALF_CIRCLE) ?
               sts_pkg::FULL_CIRCLE - diff_abs : diff_abs;
        turned = diff > {1'b0, cfg.heading_tolerance};
    end

    // No fix when either coordinate is zero
    assign no_fix = (item.easting == '0) || (item.northing == '0);

    // Gap including this ping, saturating; first ping counts as zero
    always_comb
    begin
        if (first_ping_reg)
            gap = '0;
        else if (pings_reg == sts_pkg::GAP_MAX)
            gap = sts_pkg::GAP_MAX;
        else
            gap = pings_reg + 1'b1;
        gap_ext = 32'(gap);
    end

    // Length break only when neither other break applies
    assign too_long = !turned && !no_fix &&
                      (33'(gap) > 33'(cfg.max_segment_lines));
    assign brk = turned || no_fix || too_long;

    // Result item
    always_comb
    begin
        result.segment_break = brk;
        result.turned        = turned;
        result.no_fix        = no_fix;
        result.too_long      = too_long;
        result.gap_count     = gap_ext[sts_pkg::GAP_COUNT_W-1:0];
    end

    // State update; the last ping of a file clears everything
    always_comb
    begin
        heading_reference_next = heading_reference_reg;
        pings_next             = pings_reg;
        first_ping_next        = first_ping_reg;
        if (fire)
        begin
            if (item.last_line)
            begin
                heading_reference_next = '0;
                pings_next             = '0;
                first_ping_next        = 1'b1;
            end
            else
            begin
                if (turned)
                    heading_reference_next = hd;
                pings_next      = brk ? '0 : gap;
                first_ping_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reference_reg <= '0;
            pings_reg             <= '0;
            first_ping_reg        <= 1'b1;
        end
        else
        begin
            heading_reference_reg <= heading_reference_next;
            pings_reg             <= pings_next;
            first_ping_reg        <= first_ping_next;
        end
    end

    // Checks
    `STS_ASSERT(a_last_clears, clk, rst_n, fire && item.last_line |=> first_ping_reg && pings_reg == '0 && heading_reference_reg == '0, "state not cleared after last ping")
    `STS_ASSERT(a_break_clears_gap, clk, rst_n, fire && brk |=> pings_reg == '0, "gap not cleared after break")
    `STS_ASSERT(a_turn_moves_ref, clk, rst_n, fire && turned && !item.last_line |=> heading_reference_reg == $past(hd), "reference did not follow turn")
    `STS_ASSERT(a_hold_when_idle, clk, rst_n, !fire |=> $stable(pings_reg) && $stable(first_ping_reg), "state moved without an item")

endmodule
